// ===== rtl/sha256_byte_stream_hasher_defines.svh =====
// Assertion macros used by the SHA-256 hasher top level.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Checks that a condition implies a consequence on the same edge.
`define SHB_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence on the next edge.
`define SHB_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/shb_pkg.sv =====
// Package with types, constants and functions of the SHA-256 hasher.
package shb_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } shb_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } shb_out_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/shb_fifo.sv =====
// Small request queue between the front and the back of the hasher.
module shb_fifo
  import shb_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_valid,
  output logic    wr_stall,
  input  shb_in_t wr_data,
  output logic    rd_valid,
  input  logic    rd_take,
  output shb_in_t rd_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  shb_in_t         mem_r [Depth];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic            push, pop;

  assign wr_stall = (cnt_r == (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_take && rd_valid;
  assign rd_data  = mem_r[rp_r];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== rtl/shb_core.sv =====
// Back end: block buffer, padding, 64-round compression and digest output.
module shb_core
  import shb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  output logic     req_take,
  input  shb_in_t  req,
  output logic     out_valid,
  input  logic     out_stall,
  output shb_out_t out_data,
  output logic     busy
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_RND  = 6'b000100,
    S_ADD  = 6'b001000,
    S_PAD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t          state_r;
  logic [3:0][7:0] buf_r [16]; // one big-endian word per entry, byte 0 in the top lane
  logic [5:0]      pos_r;
  logic [63:0]     bits_r;
  logic [31:0]     h_r [8];
  logic [31:0]     v_r [8];
  logic [31:0]     w_r [16];
  logic [5:0]      t_r;
  logic [3:0]      ld_r;
  logic            fin_r;   // the current compression ends the message
  logic            lenblk_r; // the current block carries the length
  logic            pad2_r;  // second padding pass: zeros and the length only
  logic [5:0]      clr_r;   // padding sweep index
  logic [2:0]      oi_r;

  logic [31:0] wt, wn, t1, t2, s0, s1, e, a;

  assign req_take = (state_r == S_IDLE) && req_valid;
  assign busy     = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data.digest_word = h_r[oi_r];
  assign out_data.word_index  = oi_r;
  assign out_data.final_word  = (oi_r == 3'd7);

  // Schedule word and round function for the current round.
  always_comb begin
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    wn = s1 + w_r[9] + s0 + w_r[0];
    wt = (t_r < 6'd16) ? w_r[0] : wn;
    e  = v_r[4];
    a  = v_r[0];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & v_r[5]) ^ (~e & v_r[6])) + RoundK[t_r] + wt;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // Sequencer for the whole back end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      bits_r  <= '0;
      t_r     <= '0;
      ld_r    <= '0;
      fin_r   <= 1'b0;
      lenblk_r <= 1'b0;
      pad2_r  <= 1'b0;
      clr_r   <= '0;
      oi_r    <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitH[i];
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            if (req.has_byte) begin
              buf_r[pos_r[5:2]][~pos_r[1:0]] <= req.data_byte;
              bits_r <= bits_r + 64'd8;
              pos_r  <= pos_r + 6'd1;
            end
            fin_r <= req.end_of_message;
            lenblk_r <= 1'b0;
            pad2_r <= 1'b0;
            if (req.has_byte && pos_r == 6'd63) begin
              state_r <= S_LOAD;
              ld_r <= '0;
            end else if (req.end_of_message) begin
              state_r <= S_PAD;
              clr_r <= req.has_byte ? pos_r + 6'd1 : pos_r;
            end
          end
        end
        S_PAD: begin
          // Sweep to the block end: pad byte at the fill point (first pass only), zeros, then the length where it fits.
          if (!pad2_r && clr_r == pos_r) begin
            buf_r[clr_r[5:2]][~clr_r[1:0]] <= PadByte;
          end else if (clr_r >= LenStart && (pad2_r || pos_r < LenStart)) begin
            buf_r[clr_r[5:2]][~clr_r[1:0]] <= bits_r[8*(63-int'(clr_r)) +: 8];
          end else begin
            buf_r[clr_r[5:2]][~clr_r[1:0]] <= 8'h00;
          end
          clr_r <= clr_r + 6'd1;
          if (clr_r == 6'd63) begin
            lenblk_r <= pad2_r || (pos_r < LenStart);
            state_r <= S_LOAD;
            ld_r <= '0;
          end
        end
        S_LOAD: begin
          // Move one word per cycle into the schedule window.
          w_r[ld_r] <= buf_r[ld_r];
          ld_r <= ld_r + 4'd1;
          if (ld_r == 4'd15) begin
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
            t_r <= '0;
            state_r <= S_RND;
          end
        end
        S_RND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wt;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          t_r <= t_r + 6'd1;
          if (t_r == 6'd63) state_r <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (!fin_r) begin
            state_r <= S_IDLE;
          end else if (lenblk_r) begin
            state_r <= S_OUT;
            oi_r <= '0;
          end else begin
            // A full block preceded the end: pad from byte zero. Otherwise the
            // pad byte left no room for the length: zeros and length only.
            state_r <= S_PAD;
            clr_r <= '0;
            pad2_r <= (pos_r != 6'd0);
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            oi_r <= oi_r + 3'd1;
            if (oi_r == 3'd7) begin
              state_r <= S_IDLE;
              pos_r <= '0;
              bits_r <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= InitH[i];
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 hasher: 2-entry request queue ahead of a 64-round compression core.
// Bytes are taken only while the core is idle; a full block passes load, rounds and add.
// A final request adds a pad sweep and a block, maybe a second sweep and block,
// then 8 output words.
// Sustained rate is set by the one-round-per-cycle compression; no byte is taken meanwhile.
// Synchronous active-low reset restores the initial hash words and clears all counts.
`include "sha256_byte_stream_hasher_defines.svh"
module sha256_byte_stream_hasher
  import shb_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  shb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output shb_out_t out_data
);

  logic    q_valid, q_take, core_busy;
  shb_in_t q_data;

  // Front: queue of incoming requests.
  shb_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_stall(in_stall), .wr_data(in_data),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
  );

  // Back: compression core.
  shb_core u_core (
    .clk(clk), .rst_n(rst_n),
    .req_valid(q_valid), .req_take(q_take), .req(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .busy(core_busy)
  );

  `SHB_ASSERT_IMPL(a_take_idle, clk, rst_n, q_take, !core_busy, "core took a request while busy")
  `SHB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `SHB_ASSERT_IMPL(a_out_busy, clk, rst_n, out_valid, core_busy, "result shown while core idle")

endmodule

// ===== test/tb_sha256_byte_stream_hasher.sv =====
// Self-checking testbench for the SHA-256 byte stream hasher.
`timescale 1ns / 1ps
module tb_sha256_byte_stream_hasher;
  import shb_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  shb_in_t in_data;
  logic out_valid;
  logic out_stall;
  shb_out_t out_data;

  sha256_byte_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state.
  logic [31:0] hash_acc [8];
  logic [7:0] blk_bytes [64];
  logic [5:0] blk_pos;
  logic [63:0] bit_total;

  shb_out_t digest_queue [$];
  int errors;
  int idle_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_acc[i] = hash_acc[i] + v[i];
  endtask

  task automatic clear_hash_state();
    for (int i = 0; i < 8; i++) hash_acc[i] = InitH[i];
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    blk_pos = '0;
    bit_total = '0;
  endtask

  // Advances the predictor by one accepted request and queues any digest words.
  task automatic predict_digest(shb_in_t req);
    shb_out_t word;
    if (req.has_byte) begin
      blk_bytes[blk_pos] = req.data_byte;
      bit_total = bit_total + 64'd8;
      blk_pos = blk_pos + 6'd1;
      if (blk_pos == 6'd0) hash_block();
    end
    if (req.end_of_message) begin
      blk_bytes[blk_pos] = PadByte;
      for (int i = int'(blk_pos) + 1; i < 64; i++) blk_bytes[i] = 8'h00;
      if (blk_pos >= LenStart) begin
        hash_block();
        for (int i = 0; i < 56; i++) blk_bytes[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) blk_bytes[56 + i] = bit_total[63 - 8*i -: 8];
      hash_block();
      for (int i = 0; i < 8; i++) begin
        word.digest_word = hash_acc[i];
        word.word_index = 3'(i);
        word.final_word = (i == 7);
        digest_queue = {digest_queue, word};
      end
      clear_hash_state();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result checker and watchdog on the rising edge.
  always @(posedge clk) begin
    shb_out_t exp_word;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("sha256_byte_stream_hasher regression: fail");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest word %h", $time, out_data);
          errors <= errors + 1;
        end else begin
          exp_word = digest_queue.pop_front();
          if (out_data.digest_word !== exp_word.digest_word ||
              out_data.word_index !== exp_word.word_index ||
              out_data.final_word !== exp_word.final_word) begin
            $display("%0t: digest mismatch expected %h/%0d/%b actual %h/%0d/%b", $time,
                     exp_word.digest_word, exp_word.word_index, exp_word.final_word,
                     out_data.digest_word, out_data.word_index, out_data.final_word);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // Receiver stall, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Presents one request and waits until it is accepted.
  task automatic send_request(logic [7:0] b, logic hb, logic eom);
    shb_in_t req;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    req.data_byte = b;
    req.has_byte = hb;
    req.end_of_message = eom;
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(req);
    @(negedge clk);
  endtask

  // Directed rows: data byte, has byte, end of message.
  typedef struct {
    logic [7:0] b;
    logic hb;
    logic eom;
  } stim_row_t;

  stim_row_t directed_rows [] = '{
    '{8'h00, 1'b0, 1'b1},
    '{8'h61, 1'b1, 1'b0}, '{8'h62, 1'b1, 1'b0}, '{8'h63, 1'b1, 1'b1},
    '{8'hff, 1'b0, 1'b0}, '{8'hff, 1'b1, 1'b1},
    '{8'h00, 1'b1, 1'b0}, '{8'h55, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1}
  };

  // Sends one message of the given length; the final byte may ride on the end request.
  task automatic send_message(int len, bit random_noise);
    bit last_on_end;
    last_on_end = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if (random_noise && $urandom_range(9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      if (last_on_end && i == len - 1) send_request(8'($urandom), 1'b1, 1'b1);
      else send_request(8'($urandom), 1'b1, 1'b0);
    end
    if (!last_on_end) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  int sent;
  int len;
  int lengths [] = '{55, 56, 63, 64};
  int drain_count;

  initial begin
    errors = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    clear_hash_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The digest of the empty message can be read off the standard directly.
    send_request(8'h00, 1'b0, 1'b1);
    if (digest_queue.size() != 8 || digest_queue[0].digest_word != 32'he3b0c442)
      errors = errors + 1;
    foreach (directed_rows[i]) send_request(directed_rows[i].b, directed_rows[i].hb,
                                            directed_rows[i].eom);
    // Padding boundary lengths around the length field and the block end.
    foreach (lengths[i]) send_message(lengths[i], 1'b0);

    // Random messages under three idling profiles.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 33 : 0;
      sent = 0;
      while (sent < 6) begin
        len = $urandom_range(12);
        send_message(len, 1'b1);
        sent = sent + len + 1;
      end
    end
    in_valid <= 1'b0;

    // Drain the remaining digest words, then let the block settle.
    drain_count = 0;
    while (digest_queue.size() != 0) @(posedge clk);
    while (drain_count < DrainCycles) begin
      @(posedge clk);
      drain_count = drain_count + 1;
    end
    if (errors == 0 && digest_queue.size() == 0) begin
      $display("sha256_byte_stream_hasher regression: pass");
    end else begin
      $display("sha256_byte_stream_hasher regression: fail");
    end
    $finish;
  end

endmodule
